[hdl/signed_int_to_decimal_glyphs_assert.svh]
// Assertion macros shared by the signed_int_to_decimal_glyphs RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SIGNED_INT_TO_DECIMAL_GLYPHS_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_GLYPHS_ASSERT_SVH

// Clocked check, switched off while the synchronous reset is held.
`define SIDG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SIDG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/sidg_pkg.sv]
// Package for the signed integer to decimal glyph converter.
// Payload structs, the classified queue entry and fixed constants; no dependencies.
`timescale 1ns / 1ps

package sidg_pkg;

  localparam int unsigned DCNT_W = 4;
  localparam int unsigned IDX_W = 7;
  localparam logic [IDX_W-1:0] MINUS_FONT_INDEX = 7'd13;
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam logic KIND_DIGIT = 1'b0;
  localparam logic KIND_MINUS = 1'b1;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [31:0]        rgba;
  } in_item_t;

  typedef struct packed {
    logic               glyph_kind;
    logic [IDX_W-1:0]   glyph_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         draw_width;
    logic [7:0]         draw_height;
    logic [31:0]        draw_color;
    logic [DCNT_W-1:0]  digit_count;
    logic               last;
  } out_item_t;

  // An accepted number after classification, as it waits for the converter.
  typedef struct packed {
    logic        is_neg;
    logic [31:0] magnitude;
    logic [15:0] minus_x;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [31:0] rgba;
  } class_item_t;

endpackage

[hdl/sidg_front.sv]
// Front end: accepts numbers, splits sign and magnitude, places the minus glyph
// and holds up to two classified numbers. Depends on sidg_pkg and the assert header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_glyphs_assert.svh"

module sidg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  sidg_pkg::in_item_t    in_data,
  input  logic [7:0]            minus_offset,
  output logic                  q_valid,
  input  logic                  q_take,
  output sidg_pkg::class_item_t q_item
);

  sidg_pkg::class_item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  logic       take;
  sidg_pkg::class_item_t cls;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign accept  = push && !full;
  assign take    = q_take && q_valid;
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    cls.is_neg       = in_data.value[31];
    // Two's complement negate as unsigned also covers the most negative value.
    cls.magnitude    = in_data.value[31] ? (32'd0 - in_data.value) : in_data.value;
    cls.minus_x      = in_data.start_x - {8'd0, minus_offset};
    cls.start_x      = in_data.start_x;
    cls.start_y      = in_data.start_y;
    cls.glyph_width  = in_data.glyph_width;
    cls.glyph_height = in_data.glyph_height;
    cls.rgba         = in_data.rgba;
  end

  always_comb begin
    wr_ptr_nxt = accept ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  `SIDG_ASSERT(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "front queue count out of range")
  `SIDG_ASSERT(a_ptr_match, clk, rst_n, (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "front queue pointers disagree with count")
  `SIDG_ASSERT(a_full_hold, clk, rst_n, (full && !take) |=> (cnt_r == 2'd2), "front queue lost an entry while full")

endmodule

[hdl/sidg_back.sv]
// Back end: splits the magnitude into decimal digits one per cycle, then sends
// the glyph run through a one-entry output register. Depends on sidg_pkg and the assert header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_glyphs_assert.svh"

module sidg_back #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_take,
  input  sidg_pkg::class_item_t q_item,
  output logic                  empty,
  input  logic                  pop,
  output sidg_pkg::out_item_t   out_data
);

  localparam int unsigned IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  sidg_pkg::class_item_t item_r;
  logic [31:0]           mag_r, mag_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  minus_pend_r, minus_pend_nxt;
  logic [15:0]           cursor_r, cursor_nxt;
  logic [3:0]            digit_r [MAX_DIGITS];
  logic                  out_valid_r, out_valid_nxt;
  sidg_pkg::out_item_t   out_r;
  sidg_pkg::out_item_t   glyph;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  rem;
  logic        conv_done;
  logic        slot_free;
  logic        emit_fire;
  logic        emit_last;

  // Divide by ten with the exact 32-bit reciprocal; the remainder is below ten
  // so its low four bits are enough.
  assign prod      = mag_r * sidg_pkg::RECIP10;
  assign quot      = {3'd0, prod[63:35]};
  assign rem       = mag_r[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
  assign conv_done = (quot == 32'd0) || ((cnt_r + 1'b1) == CNT_MAX);

  assign slot_free = !out_valid_r || pop;
  assign emit_fire = (state_r == ST_EMIT) && slot_free;
  assign emit_last = !minus_pend_r && (idx_r == '0);
  assign q_take    = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    glyph.pos_y       = item_r.start_y;
    glyph.draw_width  = item_r.glyph_width;
    glyph.draw_height = item_r.glyph_height;
    glyph.draw_color  = item_r.rgba;
    glyph.digit_count = sidg_pkg::DCNT_W'(cnt_r);
    glyph.last        = emit_last;
    if (minus_pend_r) begin
      glyph.glyph_kind  = sidg_pkg::KIND_MINUS;
      glyph.glyph_index = sidg_pkg::MINUS_FONT_INDEX;
      glyph.pos_x       = item_r.minus_x;
    end else begin
      glyph.glyph_kind  = sidg_pkg::KIND_DIGIT;
      glyph.glyph_index = {3'd0, digit_r[idx_r]};
      glyph.pos_x       = cursor_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mag_nxt        = mag_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    minus_pend_nxt = minus_pend_r;
    cursor_nxt     = cursor_r;
    out_valid_nxt  = out_valid_r && !pop;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          mag_nxt   = q_item.magnitude;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt = quot;
        cnt_nxt = cnt_r + 1'b1;
        if (conv_done) begin
          idx_nxt        = cnt_r[IW-1:0];
          minus_pend_nxt = item_r.is_neg;
          cursor_nxt     = item_r.start_x;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (minus_pend_r) begin
            minus_pend_nxt = 1'b0;
          end else begin
            cursor_nxt = cursor_r + {8'd0, item_r.glyph_width};
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      minus_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      minus_pend_r <= minus_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    cursor_r <= cursor_nxt;
    if (q_take) begin
      item_r <= q_item;
    end
    if (state_r == ST_CONV) begin
      digit_r[cnt_r[IW-1:0]] <= rem;
    end
    if (emit_fire) begin
      out_r <= glyph;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  `SIDG_ASSERT(a_conv_bound, clk, rst_n, (state_r == ST_CONV) |-> (cnt_r < CNT_MAX), "digit count ran past the digit store")
  `SIDG_ASSERT(a_last_ends_run, clk, rst_n, (emit_fire && emit_last) |=> (state_r == ST_IDLE), "run did not end after its last glyph")
  `SIDG_ASSERT(a_take_idle, clk, rst_n, q_take |=> (state_r == ST_CONV), "taken number did not start conversion")

endmodule

[hdl/signed_int_to_decimal_glyphs.sv]
// Signed 32-bit number to decimal glyph run: top level with the minus offset register.
// Instantiates sidg_front and sidg_back; types from sidg_pkg.
//
// Usage:
//   Input queue: drive in_data and raise push; the number is transferred on a
//   clock edge with push high and full low. Up to two numbers wait in the
//   front queue while the converter works on an earlier one.
//   Result queue: while empty is low, out_data holds the oldest glyph command;
//   it is transferred on an edge with pop high. A negative number gives a minus
//   glyph first, then the digits most significant first; last marks the final one.
//   Configuration: cfg_data is the minus offset, written when valid and ready
//   are both high; ready is always high. Write only while the block is idle.
//   Flow: a transferred number waits in the front queue until the converter is
//   idle and takes it; the divide-by-ten step then works out one decimal digit
//   per cycle, and the glyphs go out one per cycle through a single output
//   register while pop keeps it free. The next number is taken only after
//   the last glyph of the current one has gone out.
//   When pop stays low the glyph run pauses, then the front queue fills and full rises.
//   Reset (rst_n low, synchronous) empties both queues and sets the offset to 8.
`timescale 1ns / 1ps

module signed_int_to_decimal_glyphs #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sidg_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output sidg_pkg::out_item_t out_data,
  input  logic                valid,
  output logic                ready,
  input  logic [7:0]          cfg_data
);

  logic [7:0]            minus_offset_r, minus_offset_nxt;
  logic                  q_valid;
  logic                  q_take;
  sidg_pkg::class_item_t q_item;

  assign ready            = 1'b1;
  assign minus_offset_nxt = (valid && ready) ? cfg_data : minus_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minus_offset_r <= 8'd8;
    end else begin
      minus_offset_r <= minus_offset_nxt;
    end
  end

  sidg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data      (in_data),
    .minus_offset (minus_offset_r),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_item       (q_item)
  );

  sidg_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

[bench/tb_signed_int_to_decimal_glyphs.sv]
// Self-checking bench for signed_int_to_decimal_glyphs: random and directed numbers
// go in, and every glyph command is checked against a predicted glyph run.
// Depends on sidg_pkg and the signed_int_to_decimal_glyphs RTL.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_glyphs;

  localparam int DIGIT_SLOTS = 10;
  localparam int CONV_SLACK = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int ITEMS_PER_PHASE = 60;

  // Holds the glyph commands still owed by the block and checks each one
  // as it is transferred out.
  class glyph_board;
    sidg_pkg::out_item_t pending_glyphs[$];
    logic [7:0]  minus_offset = 8'd8;
    int          fails = 0;
    int          numbers = 0;
    int          negatives = 0;
    int          glyphs_seen = 0;

    function void note_number(sidg_pkg::in_item_t it);
      logic [31:0] mag;
      logic [3:0]  digs[DIGIT_SLOTS];
      logic [15:0] x;
      int          n;
      sidg_pkg::out_item_t g;
      mag = it.value[31] ? (~it.value + 32'd1) : it.value;
      n = 0;
      do begin
        digs[n] = 4'(mag % 10);
        mag = mag / 10;
        n++;
      end while (mag != 0 && n < DIGIT_SLOTS);
      g.pos_y = it.start_y;
      g.draw_width = it.glyph_width;
      g.draw_height = it.glyph_height;
      g.draw_color = it.rgba;
      g.digit_count = sidg_pkg::DCNT_W'(n);
      numbers++;
      if (it.value[31]) begin
        g.glyph_kind = sidg_pkg::KIND_MINUS;
        g.glyph_index = sidg_pkg::MINUS_FONT_INDEX;
        g.pos_x = it.start_x - {8'd0, minus_offset};
        g.last = 1'b0;
        pending_glyphs.push_back(g);
        negatives++;
      end
      x = it.start_x;
      for (int i = n - 1; i >= 0; i--) begin
        g.glyph_kind = sidg_pkg::KIND_DIGIT;
        g.glyph_index = {3'd0, digs[i]};
        g.pos_x = x;
        g.last = (i == 0);
        pending_glyphs.push_back(g);
        x = x + {8'd0, it.glyph_width};
      end
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        fails++;
      end
    endfunction

    function void check_glyph(sidg_pkg::out_item_t got);
      sidg_pkg::out_item_t want;
      glyphs_seen++;
      if (pending_glyphs.size() == 0) begin
        $error("glyph command with nothing expected: 0x%0h", got);
        fails++;
        return;
      end
      want = pending_glyphs.pop_front();
      cmp("glyph_kind", 64'(want.glyph_kind), 64'(got.glyph_kind));
      cmp("glyph_index", 64'(want.glyph_index), 64'(got.glyph_index));
      cmp("pos_x", 64'($unsigned(want.pos_x)), 64'($unsigned(got.pos_x)));
      cmp("pos_y", 64'($unsigned(want.pos_y)), 64'($unsigned(got.pos_y)));
      cmp("draw_width", 64'(want.draw_width), 64'(got.draw_width));
      cmp("draw_height", 64'(want.draw_height), 64'(got.draw_height));
      cmp("draw_color", 64'(want.draw_color), 64'(got.draw_color));
      cmp("digit_count", 64'(want.digit_count), 64'(got.digit_count));
      cmp("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  sidg_pkg::in_item_t  in_data;
  logic        empty;
  logic        pop;
  sidg_pkg::out_item_t out_data;
  logic        valid;
  logic        ready;
  logic [7:0]  cfg_data;

  glyph_board  board = new();
  int          send_idle = 15;
  int          recv_idle = 45;
  bit          hold_request = 1'b0;
  int          offset_settings = 1;
  int unsigned cycle_count = 0;

  signed_int_to_decimal_glyphs #(.MAX_DIGITS(DIGIT_SLOTS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .valid    (valid),
    .ready    (ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: random pops, with a long hold-off when the sender asks for one.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      board.check_glyph(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("run did not finish within %0d cycles", LIMIT_CYCLES);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic sidg_pkg::in_item_t make_number(logic [31:0] value, logic [15:0] sx,
                                                     logic [15:0] sy, logic [7:0] w,
                                                     logic [7:0] h, logic [31:0] rgba);
    sidg_pkg::in_item_t it;
    it.value = value;
    it.start_x = sx;
    it.start_y = sy;
    it.glyph_width = w;
    it.glyph_height = h;
    it.rgba = rgba;
    return it;
  endfunction

  // Mostly numbers of a chosen digit count with a random sign; some fully random.
  function automatic sidg_pkg::in_item_t random_number();
    int          digits;
    longint      lo;
    longint      hi;
    logic [31:0] v;
    digits = $urandom_range(1, DIGIT_SLOTS);
    lo = (digits == 1) ? 0 : 1;
    for (int i = 1; i < digits; i++) begin
      lo = lo * 10;
    end
    hi = (digits == 1) ? 9 : lo * 10 - 1;
    if (hi > 2147483647) begin
      hi = 2147483647;
    end
    v = $urandom_range(32'(hi), 32'(lo));
    if ($urandom_range(1)) begin
      v = ~v + 32'd1;
    end
    if ($urandom_range(7) == 0) begin
      v = $urandom();
    end
    return make_number(v, 16'($urandom()), 16'($urandom()), 8'($urandom()),
                       8'($urandom()), $urandom());
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_number(sidg_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    board.note_number(it);
    @(negedge clk);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (board.pending_glyphs.size() != 0);
    repeat (CONV_SLACK) @(negedge clk);
  endtask

  task automatic write_offset(logic [7:0] v);
    valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!ready);
    board.minus_offset = v;
    offset_settings++;
    @(negedge clk);
    valid <= 1'b0;
  endtask

  task automatic run_random(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 8) begin
        hold_request = 1'b1;
      end
      if (with_hold && i == count / 2) begin
        drain_results();
      end
      send_number(random_number());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    valid = 1'b0;
    in_data = '0;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed numbers at the reset offset: zero, single digits, powers of ten,
    // both extremes of the value, and positions that wrap in 16 bits.
    send_number(make_number(32'd0, 16'd100, 16'd50, 8'd8, 8'd12, 32'hFFFFFFFF));
    send_number(make_number(32'd1, 16'd0, 16'd0, 8'd0, 8'd0, 32'h00000000));
    send_number(make_number(-32'sd1, 16'd20, 16'd20, 8'd9, 8'd9, 32'h12345678));
    send_number(make_number(32'd9, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255, 32'hA5A5A5A5));
    send_number(make_number(32'd10, 16'h8000, 16'h8000, 8'd1, 8'd1, 32'h5A5A5A5A));
    send_number(make_number(-32'sd10, 16'h8000, 16'h1234, 8'd7, 8'd3, 32'hDEADBEEF));
    send_number(make_number(32'h7FFFFFFF, 16'h7F00, 16'd5, 8'd255, 8'd200, 32'hFF00FF00));
    send_number(make_number(32'h80000000, 16'd3, 16'hFFFF, 8'd16, 8'd16, 32'h00FF00FF));
    send_number(make_number(32'd1000000000, 16'hFFF0, 16'd7, 8'd12, 8'd14, 32'h0F0F0F0F));
    send_number(make_number(-32'sd999999999, 16'd0, 16'd0, 8'd6, 8'd8, 32'hF0F0F0F0));
    send_number(make_number(32'd99, 16'd4, 16'd4, 8'd128, 8'd64, 32'h80000001));
    send_number(make_number(-32'sd100, 16'd2, 16'd9, 8'd2, 8'd2, 32'h7FFFFFFE));
    send_number(make_number(32'd4294967295, 16'd7, 16'd1, 8'd10, 8'd10, 32'h01020304));
    send_number(make_number(32'd1234567890, 16'd1, 16'd2, 8'd8, 8'd8, 32'h11223344));
    send_number(make_number(-32'sd1234567890, 16'd8, 16'd8, 8'd8, 8'd8, 32'h55667788));
    drain_results();

    write_offset(8'd0);
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    send_idle = 45;
    recv_idle = 15;
    write_offset(8'd255);
    run_random(ITEMS_PER_PHASE, 1'b0);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    write_offset(8'($urandom_range(1, 254)));
    run_random(ITEMS_PER_PHASE, 1'b1);
    drain_results();

    $display("Converted %0d numbers (%0d negative) into %0d glyph commands",
             board.numbers, board.negatives, board.glyphs_seen);
    $display("across %0d minus offset settings, with a long output hold-off.",
             offset_settings);
    if (board.fails == 0 && board.pending_glyphs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/sidg_pkg.sv
hdl/sidg_front.sv
hdl/sidg_back.sv
hdl/signed_int_to_decimal_glyphs.sv
bench/tb_signed_int_to_decimal_glyphs.sv
